### hdl/assert_macros.svh
// Assertion macros for the RTL files that check their own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_AT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

### hdl/cfa_pkg.sv
// Package: sizes, codes, state type and control structs of the fit allocator.
package cfa_pkg;
	localparam int POOL_DEPTH = 256;
	localparam int AW = $clog2(POOL_DEPTH);
	localparam int CW = AW + 1;
	localparam int LW = AW + 1;
	localparam int SW = 9;
	localparam int FW = ((AW > SW) ? AW : SW) + 1;

	localparam logic [7:0] FREE_MARK = 8'd46;

	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_FREE    = 2'd1,
		OP_COMPACT = 2'd2,
		OP_READ    = 2'd3
	} op_t;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_NO_FIT   = 2'd1;
	localparam logic [1:0] STAT_NO_OWNER = 2'd2;
	localparam logic [1:0] STAT_MARKER   = 2'd3;

	localparam logic [1:0] POL_FIRST   = 2'd0;
	localparam logic [1:0] POL_BEST    = 2'd1;
	localparam logic [1:0] POL_WORST   = 2'd2;
	localparam logic [1:0] POL_INVALID = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_FILL,
		S_TAIL,
		S_READ,
		S_RDATA,
		S_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic scan_run;
		logic fill_run;
		logic tail_clear;
		logic rd_issue;
		logic rd_capture;
		logic res_load;
	} cfa_cmd_t;

	typedef struct packed {
		op_t  op;
		logic marker_owner;
		logic bad_policy;
		logic scan_done;
		logic found;
		logic fill_done;
		logic tail_done;
		logic res_full;
	} cfa_stat_t;
endpackage

### hdl/cfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cfa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### hdl/cfa_datapath.sv
// Datapath: pool memory, valid bits, run scanner, fill and compact pointers, result register.
module cfa_datapath import cfa_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfa_cmd_t   cmd,
	output cfa_stat_t  stat,
	input  logic [1:0] command,
	input  logic [7:0] owner,
	input  logic [8:0] request_size,
	input  logic [1:0] fit_policy,
	input  logic [7:0] cell_address,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] status,
	output logic [7:0] start_address,
	output logic [7:0] cell_value
);
	op_t               op_q;
	logic [7:0]        owner_q;
	logic [SW-1:0]     size_q;
	logic [1:0]        pol_q;
	logic [7:0]        addr_q;
	logic [CW-1:0]     r_q;
	logic [CW-1:0]     w_q;
	logic [SW-1:0]     k_q;
	logic              pv_s1;
	logic [AW-1:0]     p_s1;
	logic              vld_s1;
	logic              rng_s1;
	logic [POOL_DEPTH-1:0] valid_q;
	logic              in_run_q;
	logic [AW-1:0]     run_start_q;
	logic [LW-1:0]     run_len_q;
	logic              found_q;
	logic [AW-1:0]     best_start_q;
	logic [LW-1:0]     best_len_q;
	logic              hit_q;
	logic [7:0]        cell_q;
	logic              out_valid_q;
	logic [1:0]        status_q;
	logic [7:0]        start_q;
	logic [7:0]        value_q;

	logic              issue;
	logic [AW-1:0]     raddr;
	logic [7:0]        ram_q;
	logic [7:0]        cur;
	logic              cur_free;
	logic              is_last;
	logic [LW-1:0]     new_len;
	logic [AW-1:0]     new_start;
	logic              ev;
	logic [AW-1:0]     ev_start;
	logic [LW-1:0]     ev_len;
	logic              take;
	logic [FW-1:0]     fill_addr;
	logic              fill_done;
	logic              we;
	logic [AW-1:0]     waddr;
	logic [7:0]        wdata;
	logic              cmp_wr;
	logic              fill_wr;
	logic              tail_wr;
	logic              rd_in_range;
	logic [1:0]        res_status;

	assign issue       = cmd.scan_run && (r_q < CW'(POOL_DEPTH));
	assign rd_in_range = int'(addr_q) < POOL_DEPTH;
	assign raddr       = cmd.rd_issue ? AW'(addr_q) : r_q[AW-1:0];

	assign cur      = vld_s1 ? ram_q : FREE_MARK;
	assign cur_free = (cur == FREE_MARK);
	assign is_last  = (p_s1 == AW'(POOL_DEPTH - 1));

	// Run tracker: a run closes at an allocated cell or at the last cell.
	assign new_len   = in_run_q ? run_len_q + LW'(1) : LW'(1);
	assign new_start = in_run_q ? run_start_q : p_s1;
	assign ev        = pv_s1 && (op_q == OP_ALLOC) &&
		((cur_free && is_last) || (!cur_free && in_run_q));
	assign ev_start  = cur_free ? new_start : run_start_q;
	assign ev_len    = cur_free ? new_len : run_len_q;
	assign take      = ev && (FW'(ev_len) >= FW'(size_q)) && (!found_q ||
		(pol_q == POL_BEST && ev_len < best_len_q) ||
		(pol_q == POL_WORST && ev_len > best_len_q));

	assign fill_addr = FW'(best_start_q) + FW'(k_q);
	assign fill_done = (k_q == size_q) || (fill_addr >= FW'(POOL_DEPTH));

	assign cmp_wr  = pv_s1 && (op_q == OP_COMPACT) && !cur_free;
	assign fill_wr = cmd.fill_run && !fill_done;
	// Tail of a compact: one valid bit cleared per cycle.
	assign tail_wr = cmd.tail_clear && (w_q < CW'(POOL_DEPTH));

	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = '0;
		if (cmp_wr) begin
			we    = 1'b1;
			waddr = w_q[AW-1:0];
			wdata = cur;
		end else if (fill_wr) begin
			we    = 1'b1;
			waddr = fill_addr[AW-1:0];
			wdata = owner_q;
		end
	end

	cfa_ram #(.WIDTH(8), .DEPTH(POOL_DEPTH)) u_pool (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (ram_q)
	);

	// Request latch and scan pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q         <= OP_ALLOC;
			r_q          <= '0;
			w_q          <= '0;
			k_q          <= '0;
			pv_s1        <= 1'b0;
			in_run_q     <= 1'b0;
			found_q      <= 1'b0;
			hit_q        <= 1'b0;
			valid_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			pv_s1 <= issue;
			if (cmd.load) begin
				op_q     <= op_t'(command);
				r_q      <= '0;
				w_q      <= '0;
				k_q      <= '0;
				pv_s1    <= 1'b0;
				in_run_q <= 1'b0;
				found_q  <= 1'b0;
				hit_q    <= 1'b0;
			end else begin
				if (issue) begin
					r_q <= r_q + CW'(1);
				end
				if (pv_s1) begin
					in_run_q <= cur_free;
				end
				if (take) begin
					found_q <= 1'b1;
				end
				if (pv_s1 && op_q == OP_FREE && cur == owner_q) begin
					valid_q[p_s1] <= 1'b0;
					hit_q         <= 1'b1;
				end
				if (cmp_wr) begin
					valid_q[w_q[AW-1:0]] <= 1'b1;
					w_q                  <= w_q + CW'(1);
				end
				if (fill_wr) begin
					valid_q[fill_addr[AW-1:0]] <= 1'b1;
					k_q                        <= k_q + SW'(1);
				end
				if (tail_wr) begin
					valid_q[w_q[AW-1:0]] <= 1'b0;
					w_q                  <= w_q + CW'(1);
				end
			end
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			owner_q <= owner;
			size_q  <= request_size;
			pol_q   <= fit_policy;
			addr_q  <= cell_address;
		end
		p_s1   <= raddr;
		vld_s1 <= valid_q[raddr];
		rng_s1 <= rd_in_range;
		if (pv_s1 && cur_free) begin
			run_start_q <= new_start;
			run_len_q   <= new_len;
		end
		if (take) begin
			best_start_q <= ev_start;
			best_len_q   <= ev_len;
		end
		if (cmd.rd_capture) begin
			cell_q <= rng_s1 ? cur : 8'd0;
		end
		if (cmd.res_load) begin
			status_q <= res_status;
			start_q  <= (op_q == OP_ALLOC && res_status == STAT_OK) ? 8'(best_start_q) : 8'd0;
			value_q  <= (op_q == OP_READ) ? cell_q : 8'd0;
		end
	end

	always_comb begin
		res_status = STAT_OK;
		unique case (op_q)
			OP_ALLOC: begin
				if (owner_q == FREE_MARK) res_status = STAT_MARKER;
				else if (pol_q == POL_INVALID || !found_q) res_status = STAT_NO_FIT;
			end
			OP_FREE: begin
				if (owner_q == FREE_MARK) res_status = STAT_MARKER;
				else if (!hit_q) res_status = STAT_NO_OWNER;
			end
			OP_COMPACT: res_status = STAT_OK;
			OP_READ:    res_status = STAT_OK;
			default:    res_status = STAT_OK;
		endcase
	end

	assign stat.op           = op_q;
	assign stat.marker_owner = (owner_q == FREE_MARK);
	assign stat.bad_policy   = (pol_q == POL_INVALID);
	assign stat.scan_done    = (r_q == CW'(POOL_DEPTH)) && !pv_s1;
	assign stat.found        = found_q;
	assign stat.fill_done    = fill_done;
	assign stat.tail_done    = (w_q == CW'(POOL_DEPTH));
	assign stat.res_full     = out_valid_q;

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign start_address = start_q;
	assign cell_value    = value_q;
endmodule

### hdl/cfa_ctrl.sv
// Controller: sequences scan, fill, tail clear, cell read and result hand-off.
module cfa_ctrl import cfa_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  cfa_stat_t stat,
	output cfa_cmd_t  cmd
);
	state_t state_q;
	state_t state_nx;
	logic   skip;

	// Marker owner or invalid policy: no scan at all.
	assign skip = ((stat.op == OP_ALLOC || stat.op == OP_FREE) && stat.marker_owner) ||
		(stat.op == OP_ALLOC && stat.bad_policy);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_nx = S_SCAN;
				end
			end
			S_SCAN: begin
				if (stat.op == OP_READ) state_nx = S_READ;
				else if (skip) state_nx = S_DONE;
				else if (stat.scan_done) begin
					if (stat.op == OP_ALLOC && stat.found) state_nx = S_FILL;
					else if (stat.op == OP_COMPACT) state_nx = S_TAIL;
					else state_nx = S_DONE;
				end
			end
			S_FILL:  if (stat.fill_done) state_nx = S_DONE;
			S_TAIL:  if (stat.tail_done) state_nx = S_DONE;
			S_READ:  state_nx = S_RDATA;
			S_RDATA: state_nx = S_DONE;
			S_DONE:  if (!stat.res_full) state_nx = S_IDLE;
			default: state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE:  cmd.load = in_valid;
			S_SCAN:  cmd.scan_run = (stat.op != OP_READ) && !skip;
			S_FILL:  cmd.fill_run = 1'b1;
			S_TAIL:  cmd.tail_clear = 1'b1;
			S_READ:  cmd.rd_issue = 1'b1;
			S_RDATA: cmd.rd_capture = 1'b1;
			S_DONE:  cmd.res_load = !stat.res_full;
			default: cmd = '0;
		endcase
	end

	assign in_stall = (state_q != S_IDLE);
endmodule

### hdl/contiguous_fit_allocator_unit.sv
// Top level of the contiguous first/best/worst fit allocator over a byte-cell pool.
// Input channel (in_valid/in_stall) carries one request per transfer: command,
// owner, request_size, fit_policy and cell_address. Output channel
// (out_valid/out_stall) returns one result per request: status, start_address
// and cell_value. One request is worked on at a time; in_stall is high from the
// cycle after a transfer until the controller is idle again.
// Work per request: allocate scans the pool, then fills request_size cells
//   of the chosen run; free scans the pool; compact scans the pool, then
//   clears the valid bit of each cell left at the tail; read-cell reads one
//   cell; a marker owner or invalid policy skips the scan.
// The result sits in an output register, so the next request is taken while it
// waits; a request that finishes while that register is still full waits in the
// controller until out_stall lets the older result go.
// Reset clears all per-cell valid bits, so every cell reads as free at once;
// no clearing pass is needed.
`include "assert_macros.svh"
module contiguous_fit_allocator_unit import cfa_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] command,
	input  logic [7:0] owner,
	input  logic [8:0] request_size,
	input  logic [1:0] fit_policy,
	input  logic [7:0] cell_address,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] status,
	output logic [7:0] start_address,
	output logic [7:0] cell_value
);
	cfa_cmd_t  cmd;
	cfa_stat_t stat;

	// Controller: walks scan, fill/tail, read and result hand-off states.
	cfa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Datapath: pool memory with valid bits, run scanner, pointers, result register.
	cfa_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.command       (command),
		.owner         (owner),
		.request_size  (request_size),
		.fit_policy    (fit_policy),
		.cell_address  (cell_address),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.start_address (start_address),
		.cell_value    (cell_value)
	);

	// A transfer in always makes the block busy next cycle.
	`ASSERT_AT(a_busy_after_in, (in_valid && !in_stall) |=> in_stall, "not busy after transfer")
	// Failed requests report no address and no cell value.
	`ASSERT_AT(a_fail_clean, (out_valid && status != STAT_OK) |->
		(start_address == 8'd0 && cell_value == 8'd0), "failed result carries data")
	// A new result only appears while the block is working on a request.
	`ASSERT_AT(a_result_busy, $rose(out_valid) |-> $past(in_stall), "result without request")
endmodule
